>>> hdl/pdtb_pkg.sv
// ----------------------------------------------------------------------------
// pdtb_pkg
// Shared types and constants for the descriptor table builder.
// ----------------------------------------------------------------------------
package pdtb_pkg;

  localparam int unsigned MAX_ENTRIES = 256;
  localparam int unsigned CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned IDX_W       = 8;
  localparam int unsigned ADDR_W      = 32;
  localparam int unsigned LEN_W       = 21;
  localparam int unsigned WORD_W      = 32;

  localparam logic [LEN_W-1:0]  SEG_LIMIT = 21'h10_0000;
  localparam logic [16:0]       BOUNDARY  = 17'h1_0000;
  localparam logic [WORD_W-1:0] HALF_LEN  = 32'h0000_8000;
  localparam logic [WORD_W-1:0] END_BIT   = 32'h8000_0000;

  typedef enum logic [1:0] {
    RES_ENTRY    = 2'd0,
    RES_FULL     = 2'd1,
    RES_EMPTY    = 2'd2,
    RES_TOO_LONG = 2'd3
  } res_code_e;

  typedef struct packed {
    logic      load;       // take a new segment into the working registers
    logic      drop;       // segment swallowed after a failure
    logic      add;        // create one descriptor from the current chunk
    logic      add_half;   // second 32 KiB half of a full 64 KiB chunk
    logic      advance;    // move past the current chunk
    logic      set_fail;
    res_code_e fail_code;
    logic      fail_emit;
    logic      end_emit;   // close out the segment
  } pdtb_cmd_t;

  typedef struct packed {
    logic aborted;
    logic too_long;
    logic len_zero;
    logic table_full;
    logic split;
    logic chunk_final;
    logic out_free;
  } pdtb_stat_t;

endpackage

>>> hdl/pdtb_ctrl.sv
// ----------------------------------------------------------------------------
// pdtb_ctrl
// Sequencer: walks a segment chunk by chunk, one descriptor step per cycle while the output register is free.
// ----------------------------------------------------------------------------
module pdtb_ctrl import pdtb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  pdtb_stat_t stat_i,
  output pdtb_cmd_t  cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SEG  = 5'b00010,
    S_HALF = 5'b00100,
    S_FAIL = 5'b01000,
    S_END  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.fail_code = RES_ENTRY;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (stat_i.aborted) begin
            cmd_o.drop = 1'b1;
          end else begin
            cmd_o.load = 1'b1;
            state_d    = S_SEG;
          end
        end
      end
      S_SEG: begin
        if (stat_i.out_free) begin
          if (stat_i.too_long) begin
            cmd_o.set_fail  = 1'b1;
            cmd_o.fail_code = RES_TOO_LONG;
            state_d         = S_FAIL;
          end else if (stat_i.len_zero) begin
            state_d = S_END;
          end else if (stat_i.table_full) begin
            cmd_o.set_fail  = 1'b1;
            cmd_o.fail_code = RES_FULL;
            state_d         = S_FAIL;
          end else if (stat_i.split) begin
            cmd_o.add = 1'b1;
            state_d   = S_HALF;
          end else begin
            cmd_o.add     = 1'b1;
            cmd_o.advance = 1'b1;
            state_d       = stat_i.chunk_final ? S_END : S_SEG;
          end
        end
      end
      S_HALF: begin
        if (stat_i.out_free) begin
          if (stat_i.table_full) begin
            cmd_o.set_fail  = 1'b1;
            cmd_o.fail_code = RES_FULL;
            state_d         = S_FAIL;
          end else begin
            cmd_o.add      = 1'b1;
            cmd_o.add_half = 1'b1;
            cmd_o.advance  = 1'b1;
            state_d        = stat_i.chunk_final ? S_END : S_SEG;
          end
        end
      end
      S_FAIL: begin
        if (stat_i.out_free) begin
          cmd_o.fail_emit = 1'b1;
          state_d         = S_IDLE;
        end
      end
      S_END: begin
        if (stat_i.out_free) begin
          cmd_o.end_emit = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> hdl/pdtb_datapath.sv
// ----------------------------------------------------------------------------
// pdtb_datapath
// Segment registers, chunk arithmetic, held descriptor and output register.
// ----------------------------------------------------------------------------
module pdtb_datapath import pdtb_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic                    cfg_wdata_i,
  input  logic [ADDR_W-1:0]       seg_addr_i,
  input  logic [LEN_W-1:0]        seg_len_i,
  input  logic                    seg_last_i,
  input  pdtb_cmd_t               cmd_i,
  output pdtb_stat_t              stat_o,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [ADDR_W-1:0]       out_addr_o,
  output logic [WORD_W-1:0]       out_word_o,
  output logic [IDX_W-1:0]        out_index_o,
  output res_code_e               out_status_o,
  output logic                    out_last_o
);

  logic              mode_q;
  logic [ADDR_W-1:0] addr_q;
  logic [LEN_W-1:0]  len_q;
  logic              last_q;
  res_code_e         fail_q;

  logic              held_valid_q, held_valid_d;
  logic [ADDR_W-1:0] held_addr_q, held_addr_d;
  logic [WORD_W-1:0] held_ctl_q, held_ctl_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              aborted_q, aborted_d;

  logic              ov_q, ov_d;
  logic [ADDR_W-1:0] oa_q, oa_d;
  logic [WORD_W-1:0] ow_q, ow_d;
  logic [IDX_W-1:0]  oi_q, oi_d;
  res_code_e         os_q, os_d;
  logic              ol_q, ol_d;

  logic [16:0]       room;
  logic [LEN_W-1:0]  bcount;
  logic [15:0]       xcount;
  logic              chunk_final;
  logic [WORD_W-1:0] new_ctl;
  logic [ADDR_W-1:0] new_addr;
  logic [CNT_W-1:0]  last_idx;
  logic              out_free;

  // bytes left before the next 64 KiB boundary
  assign room        = BOUNDARY - {1'b0, addr_q[15:0]};
  assign chunk_final = ({{(LEN_W-17){1'b0}}, room} >= len_q);
  assign bcount      = chunk_final ? len_q : {{(LEN_W-17){1'b0}}, room};
  assign xcount      = bcount[15:0];
  assign last_idx    = cnt_q - CNT_W'(1);
  assign out_free    = !ov_q || out_ready_i;

  always_comb begin
    if (cmd_i.add_half) begin
      new_addr = addr_q + HALF_LEN;
      new_ctl  = HALF_LEN;
    end else if (mode_q) begin
      // word count minus one in the upper half, modulo 2^16
      new_addr = addr_q;
      new_ctl  = {({2'b00, xcount[15:2]} - 16'd1), 16'h0000};
    end else if (xcount == 16'h0000) begin
      new_addr = addr_q;
      new_ctl  = HALF_LEN;
    end else begin
      new_addr = addr_q;
      new_ctl  = {16'h0000, xcount};
    end
  end

  assign stat_o.aborted     = aborted_q;
  assign stat_o.too_long    = (len_q > SEG_LIMIT);
  assign stat_o.len_zero    = (len_q == '0);
  assign stat_o.table_full  = (cnt_q >= CNT_W'(MAX_ENTRIES));
  assign stat_o.split       = !mode_q && (xcount == 16'h0000);
  assign stat_o.chunk_final = chunk_final;
  assign stat_o.out_free    = out_free;

  always_comb begin
    held_valid_d = held_valid_q;
    held_addr_d  = held_addr_q;
    held_ctl_d   = held_ctl_q;
    cnt_d        = cnt_q;
    aborted_d    = aborted_q;
    ov_d = out_ready_i ? 1'b0 : ov_q;
    oa_d = oa_q;
    ow_d = ow_q;
    oi_d = oi_q;
    os_d = os_q;
    ol_d = ol_q;

    if (cmd_i.drop && seg_last_i) begin
      held_valid_d = 1'b0;
      cnt_d        = '0;
      aborted_d    = 1'b0;
    end

    if (cmd_i.add) begin
      if (held_valid_q) begin
        ov_d = 1'b1;
        oa_d = held_addr_q;
        ow_d = held_ctl_q;
        oi_d = IDX_W'(last_idx);
        os_d = RES_ENTRY;
        ol_d = !last_q && cmd_i.advance && chunk_final;
      end
      held_valid_d = 1'b1;
      held_addr_d  = new_addr;
      held_ctl_d   = new_ctl;
      cnt_d        = cnt_q + CNT_W'(1);
    end

    if (cmd_i.fail_emit) begin
      ov_d = 1'b1;
      oa_d = '0;
      ow_d = '0;
      oi_d = '0;
      os_d = fail_q;
      ol_d = 1'b1;
      held_valid_d = 1'b0;
      if (last_q) begin
        cnt_d     = '0;
        aborted_d = 1'b0;
      end else begin
        aborted_d = 1'b1;
      end
    end

    if (cmd_i.end_emit && last_q) begin
      ov_d = 1'b1;
      ol_d = 1'b1;
      if (held_valid_q) begin
        oa_d = held_addr_q;
        ow_d = mode_q ? held_ctl_q : (held_ctl_q | END_BIT);
        oi_d = IDX_W'(last_idx);
        os_d = RES_ENTRY;
      end else begin
        oa_d = '0;
        ow_d = '0;
        oi_d = '0;
        os_d = RES_EMPTY;
      end
      held_valid_d = 1'b0;
      cnt_d        = '0;
      aborted_d    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= 1'b0;
      held_valid_q <= 1'b0;
      cnt_q        <= '0;
      aborted_q    <= 1'b0;
      ov_q         <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      held_valid_q <= held_valid_d;
      cnt_q        <= cnt_d;
      aborted_q    <= aborted_d;
      ov_q         <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      addr_q <= seg_addr_i;
      len_q  <= seg_len_i;
      last_q <= seg_last_i;
    end else if (cmd_i.advance) begin
      addr_q <= addr_q + ADDR_W'(bcount);
      len_q  <= len_q - bcount;
    end
    if (cmd_i.set_fail) begin
      fail_q <= cmd_i.fail_code;
    end
    held_addr_q <= held_addr_d;
    held_ctl_q  <= held_ctl_d;
    oa_q <= oa_d;
    ow_q <= ow_d;
    oi_q <= oi_d;
    os_q <= os_d;
    ol_q <= ol_d;
  end

  assign out_valid_o  = ov_q;
  assign out_addr_o   = oa_q;
  assign out_word_o   = ow_q;
  assign out_index_o  = oi_q;
  assign out_status_o = os_q;
  assign out_last_o   = ol_q;

endmodule

>>> hdl/prd_descriptor_table_builder_unit.sv
// ----------------------------------------------------------------------------
// prd_descriptor_table_builder_unit
// Splits scatter-gather segments into 64 KiB-safe region descriptors.
// ----------------------------------------------------------------------------
// Each segment beat is split into descriptors that never cross a 64 KiB
// boundary; the newest descriptor is held back until the next one arrives or
// the last segment of the request closes the table. One descriptor step runs
// per cycle, and a full 64 KiB chunk in byte mode yields two descriptors;
// the sequencer stalls whenever the output register is still full. A segment
// that follows a failure in the same request is swallowed. Results come out
// of a single output register; failures carry tlast and zero data.
module prd_descriptor_table_builder_unit import pdtb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,     // word-count mode select
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,    // seg_addr[31:0], seg_len[52:32], zero pad
  input  logic        s_axis_tlast,    // seg_last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,    // entry_addr[31:0], entry_word[63:32],
                                       // entry_index[71:64]
  output logic [1:0]  m_axis_tuser,    // status
  output logic        m_axis_tlast     // last_of_item
);

  pdtb_cmd_t         cmd;
  pdtb_stat_t        stat;
  logic [ADDR_W-1:0] out_addr;
  logic [WORD_W-1:0] out_word;
  logic [IDX_W-1:0]  out_index;
  res_code_e         out_status;

  pdtb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  pdtb_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .seg_addr_i   (s_axis_tdata[31:0]),
    .seg_len_i    (s_axis_tdata[52:32]),
    .seg_last_i   (s_axis_tlast),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_addr_o   (out_addr),
    .out_word_o   (out_word),
    .out_index_o  (out_index),
    .out_status_o (out_status),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {out_index, out_word, out_addr};
  assign m_axis_tuser = out_status;

  // a failure or empty-table beat always ends its segment's results
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != RES_ENTRY) |-> m_axis_tlast)
    else $error("failure beat without tlast");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != RES_ENTRY) |-> (m_axis_tdata == '0))
    else $error("failure beat with nonzero data");

  // a taken segment occupies the sequencer unless it was swallowed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && !stat.aborted |=> !s_axis_tready)
    else $error("new segment taken while one is in progress");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.add |-> !stat.table_full)
    else $error("descriptor created past table capacity");

endmodule
